// ===== design/i2cee_pkg.sv =====
// ============================================================================
// i2cee_pkg
// Shared types and constants of the serial EEPROM bus master.
// ============================================================================
package i2cee_pkg;

	localparam int MAX_BYTES = 128;
	localparam int ADDR_BITS = 16;
	localparam int LEFT_W    = $clog2(MAX_BYTES + 1);

	localparam int PHASE_W  = 16;
	localparam int DEVA_W   = 7;
	localparam int SETTLE_W = 20;
	localparam int CFG_W    = 20;
	localparam int CFGI_W   = 2;

	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 16;

	// configuration register indexes
	localparam logic [CFGI_W-1:0] CFG_PHASE_TICKS  = 2'd0;
	localparam logic [CFGI_W-1:0] CFG_DEVICE_ADDR  = 2'd1;
	localparam logic [CFGI_W-1:0] CFG_SETTLE_TICKS = 2'd2;

	// reset values of the configuration registers
	localparam logic [PHASE_W-1:0]  PHASE_TICKS_RST  = 16'd10;
	localparam logic [DEVA_W-1:0]   DEVICE_ADDR_RST  = 7'd80;
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 20'd5000;

	// input item kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_DATA  = 2'd3
	} kind_t;

	// bus phases; order matters: everything after PH_IDLE and before PH_SP_A is transfer
	typedef enum logic [4:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_ST_D,
		PH_BIT_SETUP, PH_BIT_HIGH, PH_BIT_LOW,
		PH_ACK_SETUP, PH_ACK_HIGH, PH_ACK_LOW, PH_WAIT_BYTE,
		PH_RD_HIGH, PH_RD_LOW, PH_MACK_SETUP, PH_MACK_HIGH, PH_MACK_LOW,
		PH_SP_A, PH_SP_B, PH_SP_C, PH_SETTLE
	} phase_t;

	// which byte of the access is on the bus
	typedef enum logic [2:0] {
		STG_DEV   = 3'd0,
		STG_AHI   = 3'd1,
		STG_ALO   = 3'd2,
		STG_WDATA = 3'd3,
		STG_RDEV  = 3'd4,
		STG_RDATA = 3'd5
	} stage_t;

endpackage

// ===== design/i2c_eeprom_master.sv =====
// ============================================================================
// i2c_eeprom_master
// Bus master for page reads and writes of a serial EEPROM, stepped one
// tick per input beat.
// ============================================================================
//
//  channel   dir  handshake             payload
//  --------  ---  --------------------  ------------------------------------
//  s_*       in   s_tvalid / s_tready   tuser: kind; tdata: address, count,
//                                       write byte, sampled SDA
//  m_*       out  m_tvalid / m_tready   tdata: bus levels, status, read byte
//  cfg_*     in   cfg_we (no wait)      index 0 phase ticks, 1 device
//                                       address, 2 write settle ticks
//
//  Each beat is one tick of the bit engine: a beat is held in the input
//  register, the tick is evaluated, and the result lands in the output
//  register, which drives m_tdata; a stalled output can hold a beat in the
//  input register. Input and output registers keep a beat flowing
//  every clock while m_tready is high; a stalled output holds the input side
//  after one more beat. arst_n clears the engine to idle (bus released, write
//  protect high) and loads the register defaults.
//
module i2c_eeprom_master (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [1:0] kind
	input  logic [1:0]                       s_tuser,
	// [15:0] mem_address, [23:16] byte_count, [31:24] write_byte,
	// [32] sda_in, [39:33] zero
	input  logic [i2cee_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [0] scl_level, [1] sda_release, [2] write_protect, [3] busy_res,
	// [4] need_byte, [12:5] read_byte, [13] read_valid, [14] nak_seen,
	// [15] done_res
	output logic [i2cee_pkg::M_TDATA_W-1:0]  m_tdata,
	input  logic                             cfg_we,
	input  logic [i2cee_pkg::CFGI_W-1:0]     cfg_index,
	input  logic [i2cee_pkg::CFG_W-1:0]      cfg_data
);

	// configuration
	logic [i2cee_pkg::PHASE_W-1:0]  phase_ticks_q;
	logic [i2cee_pkg::DEVA_W-1:0]   dev_addr_q;
	logic [i2cee_pkg::SETTLE_W-1:0] settle_ticks_q;

	// input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [15:0] mem_addr_s1;
	logic [7:0]  count_s1;
	logic [7:0]  wbyte_s1;
	logic        sda_s1;

	// engine state
	i2cee_pkg::phase_t                 phase_q;
	i2cee_pkg::stage_t                 stage_q;
	logic [i2cee_pkg::SETTLE_W-1:0]    tick_q;
	logic [3:0]                        bit_q;
	logic [7:0]                        shift_q;
	logic [i2cee_pkg::LEFT_W-1:0]      left_q;
	logic [i2cee_pkg::ADDR_BITS-1:0]   addr_q;
	logic                              is_read_q;
	logic [7:0]                        held_byte_q;
	logic                              held_valid_q;
	logic                              nak_q;

	// next state
	i2cee_pkg::phase_t                 n_phase;
	i2cee_pkg::stage_t                 n_stage;
	logic [i2cee_pkg::SETTLE_W-1:0]    n_tick;
	logic [3:0]                        n_bit;
	logic [7:0]                        n_shift;
	logic [i2cee_pkg::LEFT_W-1:0]      n_left;
	logic [i2cee_pkg::ADDR_BITS-1:0]   n_addr;
	logic                              n_is_read;
	logic [7:0]                        n_held_byte;
	logic                              n_held_valid;
	logic                              n_nak;

	// tick results
	logic        o_scl, o_rel, o_wp, o_busy, o_need, o_rvalid, o_done;
	logic [7:0]  o_rbyte;
	logic [7:0]  cnt_sat;
	logic [i2cee_pkg::PHASE_W-1:0]    pt_eff;
	logic [i2cee_pkg::SETTLE_W:0]     tick_inc;
	i2cee_pkg::phase_t                ph;

	logic adv;

	assign adv      = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || adv;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q  <= i2cee_pkg::PHASE_TICKS_RST;
			dev_addr_q     <= i2cee_pkg::DEVICE_ADDR_RST;
			settle_ticks_q <= i2cee_pkg::SETTLE_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				i2cee_pkg::CFG_PHASE_TICKS:  phase_ticks_q  <= cfg_data[i2cee_pkg::PHASE_W-1:0];
				i2cee_pkg::CFG_DEVICE_ADDR:  dev_addr_q     <= cfg_data[i2cee_pkg::DEVA_W-1:0];
				i2cee_pkg::CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// -------------------------------------------------------- input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1     <= s_tuser;
			mem_addr_s1 <= s_tdata[15:0];
			count_s1    <= s_tdata[23:16];
			wbyte_s1    <= s_tdata[31:24];
			sda_s1      <= s_tdata[32];
		end
	end

	// ------------------------------------------------------------ tick logic
	// zero phase ticks behaves as one
	assign pt_eff = (phase_ticks_q == '0) ? i2cee_pkg::PHASE_W'(1) : phase_ticks_q;

	always_comb begin
		if (count_s1 == 8'd0)
			cnt_sat = 8'd1;
		else if (int'(count_s1) > i2cee_pkg::MAX_BYTES)
			cnt_sat = 8'(i2cee_pkg::MAX_BYTES);
		else
			cnt_sat = count_s1;
	end

	always_comb begin
		n_phase      = phase_q;
		n_stage      = stage_q;
		n_tick       = tick_q;
		n_bit        = bit_q;
		n_shift      = shift_q;
		n_left       = left_q;
		n_addr       = addr_q;
		n_is_read    = is_read_q;
		n_held_byte  = held_byte_q;
		n_held_valid = held_valid_q;
		n_nak        = nak_q;
		o_rvalid     = 1'b0;
		o_rbyte      = 8'd0;
		o_done       = 1'b0;
		o_scl        = 1'b1;
		o_rel        = 1'b1;

		// command intake: begin only from idle, write bytes only mid-transfer
		if ((kind_s1 == i2cee_pkg::KIND_WRITE || kind_s1 == i2cee_pkg::KIND_READ)
				&& phase_q == i2cee_pkg::PH_IDLE) begin
			n_left       = i2cee_pkg::LEFT_W'(cnt_sat);
			n_addr       = i2cee_pkg::ADDR_BITS'(mem_addr_s1);
			n_is_read    = (kind_s1 == i2cee_pkg::KIND_READ);
			n_held_valid = 1'b0;
			n_nak        = 1'b0;
			n_stage      = i2cee_pkg::STG_DEV;
			n_bit        = 4'd0;
			n_phase      = i2cee_pkg::PH_ST_A;
			n_tick       = '0;
		end else if (kind_s1 == i2cee_pkg::KIND_DATA && phase_q != i2cee_pkg::PH_IDLE
				&& !is_read_q && phase_q < i2cee_pkg::PH_SP_A) begin
			n_held_byte  = wbyte_s1;
			n_held_valid = 1'b1;
		end

		// bus levels for this tick
		ph = n_phase;
		case (ph)
			i2cee_pkg::PH_ST_A:       o_scl = (n_stage != i2cee_pkg::STG_RDEV);
			i2cee_pkg::PH_ST_C:       o_rel = 1'b0;
			i2cee_pkg::PH_ST_D,
			i2cee_pkg::PH_SP_A: begin
				o_scl = 1'b0;
				o_rel = 1'b0;
			end
			i2cee_pkg::PH_BIT_SETUP,
			i2cee_pkg::PH_BIT_LOW: begin
				o_scl = 1'b0;
				o_rel = n_shift[7];
			end
			i2cee_pkg::PH_BIT_HIGH:   o_rel = n_shift[7];
			i2cee_pkg::PH_MACK_SETUP,
			i2cee_pkg::PH_MACK_LOW: begin
				o_scl = 1'b0;
				o_rel = (n_left <= i2cee_pkg::LEFT_W'(1));
			end
			i2cee_pkg::PH_MACK_HIGH:  o_rel = (n_left <= i2cee_pkg::LEFT_W'(1));
			i2cee_pkg::PH_SP_B:       o_rel = 1'b0;
			i2cee_pkg::PH_IDLE,
			i2cee_pkg::PH_ST_B,
			i2cee_pkg::PH_ACK_HIGH,
			i2cee_pkg::PH_RD_HIGH,
			i2cee_pkg::PH_SP_C,
			i2cee_pkg::PH_SETTLE:     ;
			default:                  o_scl = 1'b0;
		endcase
		o_busy = (ph != i2cee_pkg::PH_IDLE);
		o_wp   = !(o_busy && !n_is_read && ph != i2cee_pkg::PH_SETTLE);
		o_need = (ph == i2cee_pkg::PH_WAIT_BYTE) && !n_held_valid;

		tick_inc = {1'b0, n_tick} + 1'b1;

		// advance the engine
		if (ph == i2cee_pkg::PH_WAIT_BYTE) begin
			if (n_held_valid) begin
				n_held_valid = 1'b0;
				n_shift      = n_held_byte;
				n_bit        = 4'd0;
				n_phase      = i2cee_pkg::PH_BIT_SETUP;
				n_tick       = '0;
			end
		end else if (ph == i2cee_pkg::PH_SETTLE) begin
			if (tick_inc >= {1'b0, settle_ticks_q}) begin
				n_phase = i2cee_pkg::PH_IDLE;
				n_tick  = '0;
				o_done  = 1'b1;
			end else begin
				n_tick = tick_inc[i2cee_pkg::SETTLE_W-1:0];
			end
		end else if (ph != i2cee_pkg::PH_IDLE) begin
			if (tick_inc < (i2cee_pkg::SETTLE_W+1)'(pt_eff)) begin
				n_tick = tick_inc[i2cee_pkg::SETTLE_W-1:0];
			end else begin
				// end of phase
				n_tick = '0;
				case (ph)
					i2cee_pkg::PH_ST_A: n_phase = i2cee_pkg::PH_ST_B;
					i2cee_pkg::PH_ST_B: n_phase = i2cee_pkg::PH_ST_C;
					i2cee_pkg::PH_ST_C: n_phase = i2cee_pkg::PH_ST_D;
					i2cee_pkg::PH_ST_D: begin
						n_shift = {dev_addr_q, n_stage == i2cee_pkg::STG_RDEV};
						n_bit   = 4'd0;
						n_phase = i2cee_pkg::PH_BIT_SETUP;
					end
					i2cee_pkg::PH_BIT_SETUP: n_phase = i2cee_pkg::PH_BIT_HIGH;
					i2cee_pkg::PH_BIT_HIGH:  n_phase = i2cee_pkg::PH_BIT_LOW;
					i2cee_pkg::PH_BIT_LOW: begin
						n_shift = {n_shift[6:0], 1'b0};
						n_bit   = n_bit + 4'd1;
						n_phase = (n_bit >= 4'd8) ? i2cee_pkg::PH_ACK_SETUP
						                          : i2cee_pkg::PH_BIT_SETUP;
					end
					i2cee_pkg::PH_ACK_SETUP: n_phase = i2cee_pkg::PH_ACK_HIGH;
					i2cee_pkg::PH_ACK_HIGH: begin
						if (sda_s1)
							n_nak = 1'b1;
						n_phase = i2cee_pkg::PH_ACK_LOW;
					end
					i2cee_pkg::PH_ACK_LOW: begin
						case (n_stage)
							i2cee_pkg::STG_DEV: begin
								n_bit   = 4'd0;
								n_phase = i2cee_pkg::PH_BIT_SETUP;
								if (i2cee_pkg::ADDR_BITS > 8) begin
									n_stage = i2cee_pkg::STG_AHI;
									n_shift = 8'(n_addr >> 8);
								end else begin
									n_stage = i2cee_pkg::STG_ALO;
									n_shift = 8'(n_addr);
								end
							end
							i2cee_pkg::STG_AHI: begin
								n_stage = i2cee_pkg::STG_ALO;
								n_shift = 8'(n_addr);
								n_bit   = 4'd0;
								n_phase = i2cee_pkg::PH_BIT_SETUP;
							end
							i2cee_pkg::STG_ALO: begin
								if (n_is_read) begin
									n_stage = i2cee_pkg::STG_RDEV;
									n_phase = i2cee_pkg::PH_ST_A;
								end else begin
									n_stage = i2cee_pkg::STG_WDATA;
									if (n_held_valid) begin
										n_held_valid = 1'b0;
										n_shift      = n_held_byte;
										n_bit        = 4'd0;
										n_phase      = i2cee_pkg::PH_BIT_SETUP;
									end else begin
										n_phase = i2cee_pkg::PH_WAIT_BYTE;
									end
								end
							end
							i2cee_pkg::STG_WDATA: begin
								if (n_left <= i2cee_pkg::LEFT_W'(1)) begin
									n_left  = '0;
									n_phase = i2cee_pkg::PH_SP_A;
								end else begin
									n_left = n_left - 1'b1;
									if (n_held_valid) begin
										n_held_valid = 1'b0;
										n_shift      = n_held_byte;
										n_bit        = 4'd0;
										n_phase      = i2cee_pkg::PH_BIT_SETUP;
									end else begin
										n_phase = i2cee_pkg::PH_WAIT_BYTE;
									end
								end
							end
							i2cee_pkg::STG_RDEV: begin
								n_stage = i2cee_pkg::STG_RDATA;
								n_shift = 8'd0;
								n_bit   = 4'd0;
								n_phase = i2cee_pkg::PH_RD_HIGH;
							end
							default: n_phase = i2cee_pkg::PH_SP_A;
						endcase
					end
					i2cee_pkg::PH_RD_HIGH: begin
						n_shift = {n_shift[6:0], sda_s1};
						if (n_bit == 4'd7) begin
							o_rvalid = 1'b1;
							o_rbyte  = n_shift;
						end
						n_phase = i2cee_pkg::PH_RD_LOW;
					end
					i2cee_pkg::PH_RD_LOW: begin
						n_bit   = n_bit + 4'd1;
						n_phase = (n_bit >= 4'd8) ? i2cee_pkg::PH_MACK_SETUP
						                          : i2cee_pkg::PH_RD_HIGH;
					end
					i2cee_pkg::PH_MACK_SETUP: n_phase = i2cee_pkg::PH_MACK_HIGH;
					i2cee_pkg::PH_MACK_HIGH:  n_phase = i2cee_pkg::PH_MACK_LOW;
					i2cee_pkg::PH_MACK_LOW: begin
						if (n_left <= i2cee_pkg::LEFT_W'(1)) begin
							n_left  = '0;
							n_phase = i2cee_pkg::PH_SP_A;
						end else begin
							n_left  = n_left - 1'b1;
							n_shift = 8'd0;
							n_bit   = 4'd0;
							n_phase = i2cee_pkg::PH_RD_HIGH;
						end
					end
					i2cee_pkg::PH_SP_A: n_phase = i2cee_pkg::PH_SP_B;
					i2cee_pkg::PH_SP_B: n_phase = i2cee_pkg::PH_SP_C;
					i2cee_pkg::PH_SP_C: begin
						if (!n_is_read && settle_ticks_q != '0) begin
							n_phase = i2cee_pkg::PH_SETTLE;
						end else begin
							n_phase = i2cee_pkg::PH_IDLE;
							o_done  = 1'b1;
						end
					end
					default: begin
						n_phase = i2cee_pkg::PH_IDLE;
						o_done  = 1'b1;
					end
				endcase
			end
		end
	end

	// ---------------------------------------------------------- engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= i2cee_pkg::PH_IDLE;
			stage_q      <= i2cee_pkg::STG_DEV;
			tick_q       <= '0;
			bit_q        <= '0;
			shift_q      <= '0;
			left_q       <= '0;
			addr_q       <= '0;
			is_read_q    <= 1'b0;
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			nak_q        <= 1'b0;
		end else if (adv) begin
			phase_q      <= n_phase;
			stage_q      <= n_stage;
			tick_q       <= n_tick;
			bit_q        <= n_bit;
			shift_q      <= n_shift;
			left_q       <= n_left;
			addr_q       <= n_addr;
			is_read_q    <= n_is_read;
			held_byte_q  <= n_held_byte;
			held_valid_q <= n_held_valid;
			nak_q        <= n_nak;
		end
	end

	// ------------------------------------------------------- result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (adv) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata <= {o_done, n_nak, o_rvalid, o_rbyte, o_need, o_busy, o_wp, o_rel, o_scl};
		end
	end

endmodule
